// ----- rtl/ste_pkg.sv -----
// Shared types, constants and helper functions of the sprite table tile emitter.
package ste_pkg;

    localparam int SPRITE_COUNT = 64;
    localparam int IDX_W        = 6;

    typedef enum logic [2:0] {
        REQ_SET_POS   = 3'd0,
        REQ_SET_TYPE  = 3'd1,
        REQ_SET_VIS   = 3'd2,
        REQ_SET_TILES = 3'd3,
        REQ_DRAW      = 3'd4,
        REQ_COLLIDE   = 3'd5
    } t_req_code;

    typedef enum logic [2:0] {
        OP_SET_POS,
        OP_SET_TYPE,
        OP_SET_VIS,
        OP_SET_TILES,
        OP_DRAW,
        OP_COLLIDE
    } t_op;

    localparam logic RESULT_TILE    = 1'b0;
    localparam logic RESULT_COLLIDE = 1'b1;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [IDX_W-1:0] sprite_index;
        logic [IDX_W-1:0] other_index;
        logic [15:0]      pos_x;
        logic [15:0]      pos_y;
        logic [3:0]       sprite_type;
        logic             visible_flag;
        logic [7:0]       tile_0;
        logic [7:0]       tile_1;
        logic [7:0]       tile_2;
        logic [7:0]       tile_3;
    } t_req;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] tile_x;
        logic [15:0] tile_y;
        logic [7:0]  tile_number;
        logic        collided;
        logic        last;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic             idx_ok;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic [31:0]      pos;
        logic [3:0]       sprite_type;
        logic             vis;
        logic [31:0]      tiles;
    } t_cmd;

    function automatic logic [5:0] tile_size(input logic [3:0] stype);
        logic [5:0] size;
        case (stype[3:2])
            2'd0:    size = 6'd8;
            2'd1:    size = 6'd16;
            2'd2:    size = 6'd32;
            default: size = 6'd0;
        endcase
        return size;
    endfunction

    function automatic logic [15:0] extent(input logic [5:0] size, input logic doubled);
        logic [15:0] span;
        span = doubled ? {9'd0, size, 1'b0} : {10'd0, size};
        return span - 16'd1;
    endfunction

    function automatic logic index_ok(input logic [IDX_W-1:0] idx);
        return ({1'b0, idx} < (IDX_W+1)'(SPRITE_COUNT));
    endfunction

endpackage

// ----- rtl/ste_front.sv -----
// Command intake: accepts a word, classifies it and hands it on to the queue.
module ste_front import ste_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    input  logic i_q_full,
    output logic busy,
    output logic o_push,
    output t_cmd o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd cmd;
    logic keep;
    logic accept;

    assign o_push = r_valid && !i_q_full;
    assign busy   = r_valid && i_q_full;
    assign accept = start && !busy;
    assign o_cmd  = r_cmd;

    always_comb begin
        cmd.idx_a       = i_req.sprite_index;
        cmd.idx_b       = i_req.other_index;
        cmd.pos         = {i_req.pos_y, i_req.pos_x};
        cmd.sprite_type = i_req.sprite_type;
        cmd.vis         = i_req.visible_flag;
        cmd.tiles       = {i_req.tile_3, i_req.tile_2, i_req.tile_1, i_req.tile_0};
        cmd.idx_ok      = index_ok(i_req.sprite_index);
        cmd.op          = OP_DRAW;
        keep            = 1'b0;
        case (t_req_code'(i_req.req_type))
            REQ_SET_POS: begin
                cmd.op = OP_SET_POS;
                keep   = cmd.idx_ok;
            end
            REQ_SET_TYPE: begin
                cmd.op = OP_SET_TYPE;
                keep   = cmd.idx_ok;
            end
            REQ_SET_VIS: begin
                cmd.op = OP_SET_VIS;
                keep   = cmd.idx_ok;
            end
            REQ_SET_TILES: begin
                cmd.op = OP_SET_TILES;
                keep   = cmd.idx_ok;
            end
            REQ_DRAW: begin
                cmd.op = OP_DRAW;
                keep   = cmd.idx_ok;
            end
            REQ_COLLIDE: begin
                cmd.op     = OP_COLLIDE;
                cmd.idx_ok = index_ok(i_req.sprite_index) && index_ok(i_req.other_index);
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (accept && keep) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cmd;
        end
    end

endmodule

// ----- rtl/ste_queue.sv -----
// Two-entry command queue between the intake and the execution side.
module ste_queue import ste_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/ste_back.sv -----
// Execution side: sprite stores, draw sequencer and collision test.
module ste_back import ste_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_strobe,
    output t_result o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_COMPARE,
        S_DRAW
    } t_state;

    t_state r_state;

    logic [31:0] mem_pos   [SPRITE_COUNT];
    logic [3:0]  mem_type  [SPRITE_COUNT];
    logic        mem_vis   [SPRITE_COUNT];
    logic [31:0] mem_tiles [SPRITE_COUNT];

    logic [SPRITE_COUNT-1:0] r_pos_set;
    logic [SPRITE_COUNT-1:0] r_type_set;
    logic [SPRITE_COUNT-1:0] r_vis_set;
    logic [SPRITE_COUNT-1:0] r_tiles_set;

    logic [31:0] r_pos_q;
    logic [3:0]  r_type_q;
    logic        r_vis_q;
    logic [31:0] r_tiles_q;
    logic        r_pos_v;
    logic        r_type_v;
    logic        r_vis_v;
    logic        r_tiles_v;

    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      pos_rd;
    logic [3:0]       type_rd;
    logic             vis_rd;
    logic [31:0]      tiles_rd;
    logic [5:0]       size_rd;
    logic             wr_pos;
    logic             wr_type;
    logic             wr_vis;
    logic             wr_tiles;

    logic [IDX_W-1:0] r_idx_b;
    logic             r_ok;
    logic             r_is_draw;
    logic [15:0]      r_x;
    logic [15:0]      r_y;
    logic [31:0]      r_tiles;
    logic [5:0]       r_size;
    logic [1:0]       r_k;
    logic [1:0]       r_last_k;
    logic             r_a_live;
    logic [15:0]      r_wa;
    logic [15:0]      r_ha;
    logic             r_b_live;
    logic [15:0]      r_bx;
    logic [15:0]      r_by;
    logic [15:0]      r_wb;
    logic [15:0]      r_hb;
    logic [15:0]      r_aex;
    logic [15:0]      r_aey;
    logic             r_strobe;
    t_result          r_res;

    logic [15:0] bex;
    logic [15:0] bey;
    logic        hit;
    logic [15:0] step_x;
    logic [15:0] step_y;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign rd_addr  = (r_state == S_IDLE) ? i_cmd.idx_a : r_idx_b;
    assign wr_pos   = o_pop && (i_cmd.op == OP_SET_POS);
    assign wr_type  = o_pop && (i_cmd.op == OP_SET_TYPE);
    assign wr_vis   = o_pop && (i_cmd.op == OP_SET_VIS);
    assign wr_tiles = o_pop && (i_cmd.op == OP_SET_TILES);

    // An entry that was never written reads as its reset value of zero.
    assign pos_rd   = r_pos_v   ? r_pos_q   : 32'd0;
    assign type_rd  = r_type_v  ? r_type_q  : 4'd0;
    assign vis_rd   = r_vis_v   ? r_vis_q   : 1'b0;
    assign tiles_rd = r_tiles_v ? r_tiles_q : 32'd0;
    assign size_rd  = tile_size(type_rd);

    assign bex    = r_bx + r_wb;
    assign bey    = r_by + r_hb;
    assign hit    = r_ok && r_a_live && r_b_live
                    && !(r_aex < r_bx || r_x >= bex)
                    && !(r_aey < r_by || r_y > bey);
    assign step_x = r_k[0] ? {10'd0, r_size} : 16'd0;
    assign step_y = r_k[1] ? {10'd0, r_size} : 16'd0;

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (wr_pos) begin
            mem_pos[i_cmd.idx_a] <= i_cmd.pos;
        end
        if (wr_type) begin
            mem_type[i_cmd.idx_a] <= i_cmd.sprite_type;
        end
        if (wr_vis) begin
            mem_vis[i_cmd.idx_a] <= i_cmd.vis;
        end
        if (wr_tiles) begin
            mem_tiles[i_cmd.idx_a] <= i_cmd.tiles;
        end
        r_pos_q   <= mem_pos[rd_addr];
        r_type_q  <= mem_type[rd_addr];
        r_vis_q   <= mem_vis[rd_addr];
        r_tiles_q <= mem_tiles[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_set   <= '0;
            r_type_set  <= '0;
            r_vis_set   <= '0;
            r_tiles_set <= '0;
            r_pos_v     <= 1'b0;
            r_type_v    <= 1'b0;
            r_vis_v     <= 1'b0;
            r_tiles_v   <= 1'b0;
        end else begin
            if (wr_pos) begin
                r_pos_set[i_cmd.idx_a] <= 1'b1;
            end
            if (wr_type) begin
                r_type_set[i_cmd.idx_a] <= 1'b1;
            end
            if (wr_vis) begin
                r_vis_set[i_cmd.idx_a] <= 1'b1;
            end
            if (wr_tiles) begin
                r_tiles_set[i_cmd.idx_a] <= 1'b1;
            end
            r_pos_v   <= r_pos_set[rd_addr];
            r_type_v  <= r_type_set[rd_addr];
            r_vis_v   <= r_vis_set[rd_addr];
            r_tiles_v <= r_tiles_set[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_idx_b <= i_cmd.idx_b;
                        r_ok    <= i_cmd.idx_ok;
                        if (i_cmd.op == OP_DRAW) begin
                            r_is_draw <= 1'b1;
                            r_state   <= S_READ_A;
                        end else if (i_cmd.op == OP_COLLIDE) begin
                            r_is_draw <= 1'b0;
                            r_state   <= S_READ_A;
                        end
                    end
                end
                S_READ_A: begin
                    r_x      <= pos_rd[15:0];
                    r_y      <= pos_rd[31:16];
                    r_tiles  <= tiles_rd;
                    r_size   <= size_rd;
                    r_k      <= 2'd0;
                    r_a_live <= vis_rd && (size_rd != 6'd0);
                    r_wa     <= extent(size_rd, type_rd[0]);
                    r_ha     <= extent(size_rd, type_rd[1]);
                    case (type_rd[1:0])
                        2'd0:    r_last_k <= 2'd0;
                        2'd3:    r_last_k <= 2'd3;
                        default: r_last_k <= 2'd1;
                    endcase
                    if (r_is_draw) begin
                        if (vis_rd && (size_rd != 6'd0)) begin
                            r_state <= S_DRAW;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_READ_B;
                    end
                end
                S_READ_B: begin
                    r_bx     <= pos_rd[15:0];
                    r_by     <= pos_rd[31:16];
                    r_b_live <= vis_rd && (size_rd != 6'd0);
                    r_wb     <= extent(size_rd, type_rd[0]);
                    r_hb     <= extent(size_rd, type_rd[1]);
                    r_aex    <= r_x + r_wa;
                    r_aey    <= r_y + r_ha;
                    r_state  <= S_COMPARE;
                end
                S_COMPARE: begin
                    r_strobe          <= 1'b1;
                    r_res.result_kind <= RESULT_COLLIDE;
                    r_res.tile_x      <= 16'd0;
                    r_res.tile_y      <= 16'd0;
                    r_res.tile_number <= 8'd0;
                    r_res.collided    <= hit;
                    r_res.last        <= 1'b1;
                    r_state           <= S_IDLE;
                end
                S_DRAW: begin
                    r_strobe          <= 1'b1;
                    r_res.result_kind <= RESULT_TILE;
                    r_res.tile_x      <= r_x + step_x;
                    r_res.tile_y      <= r_y + step_y;
                    r_res.tile_number <= r_tiles[8*r_k +: 8];
                    r_res.collided    <= 1'b0;
                    r_res.last        <= (r_k == r_last_k);
                    if (r_k == r_last_k) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/sprite_table_tile_emitter.sv -----
// Top level of the sprite table tile emitter.
//
//   Channel   Handshake            Payload
//   command   start / busy         i_req (t_req)
//   result    o_strobe, no stall   o_result (t_result)
//
// A command word is taken when start is high and busy is low; busy rises only
// while the intake register holds a word and the two-entry queue is full.
// The execution side takes one queued word per cycle while set commands are queued,
// and takes no new word while a draw or collide is in hand: a draw reads its sprite,
// then emits one tile a cycle if the sprite is visible and has a size, and a collide
// reads its two sprites one after the other through the single read port of each
// store, then compares them. Reset is synchronous and clears the store valid bits
// at once, so there is no clearing pass. Results cannot be held off by the receiver.
module sprite_table_tile_emitter import ste_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    ste_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .i_q_full (q_full),
        .busy     (busy),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    ste_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (queue_cmd)
    );

    ste_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_cmd    (queue_cmd),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ----- verif/tb_sprite_table_tile_emitter.sv -----
// Self-checking testbench of the sprite table tile emitter: directed and random command words.
module tb_sprite_table_tile_emitter;
    import ste_pkg::*;

    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;
    localparam logic [1:0] SHAPE_1X1 = 2'd0;
    localparam logic [1:0] SHAPE_1X2 = 2'd1;
    localparam logic [1:0] SHAPE_2X1 = 2'd2;
    localparam logic [1:0] SHAPE_2X2 = 2'd3;
    localparam logic [1:0] GROUP_8 = 2'd0;
    localparam logic [1:0] GROUP_16 = 2'd1;
    localparam logic [1:0] GROUP_32 = 2'd2;
    localparam logic [1:0] GROUP_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_WORDS = 200;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_req    i_req;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    logic [31:0] sprite_pos [SPRITE_COUNT];
    logic [4:0]  sprite_attr [SPRITE_COUNT];
    logic [31:0] sprite_tiles [SPRITE_COUNT];
    t_result     due_words [$];
    t_result     head_word;
    int          mismatch_count = 0;
    int          sender_idle_pct = 10;

    sprite_table_tile_emitter DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [5:0] pixels_per_tile(input logic [3:0] stype);
        case (stype[3:2])
            GROUP_8:  return 6'd8;
            GROUP_16: return 6'd16;
            GROUP_32: return 6'd32;
            default:  return 6'd0;
        endcase
    endfunction

    function automatic logic sprite_span(input logic [4:0] attr, output logic [15:0] w,
                                         output logic [15:0] h);
        logic [15:0] sz;
        sz = {10'd0, pixels_per_tile(attr[3:0])};
        w = ((attr[1:0] == SHAPE_1X2 || attr[1:0] == SHAPE_2X2) ? 16'd2 : 16'd1) * sz - 16'd1;
        h = ((attr[1:0] == SHAPE_2X1 || attr[1:0] == SHAPE_2X2) ? 16'd2 : 16'd1) * sz - 16'd1;
        return sz != 16'd0;
    endfunction

    function automatic logic boxes_meet(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
        logic [15:0] wa, ha, wb, hb, ax, ay, bx, by, aex, aey, bex, bey;
        if (int'(a) >= SPRITE_COUNT || int'(b) >= SPRITE_COUNT)
            return 1'b0;
        if (!sprite_attr[a][4] || !sprite_attr[b][4])
            return 1'b0;
        if (!sprite_span(sprite_attr[a], wa, ha) || !sprite_span(sprite_attr[b], wb, hb))
            return 1'b0;
        ax = sprite_pos[a][15:0];
        ay = sprite_pos[a][31:16];
        bx = sprite_pos[b][15:0];
        by = sprite_pos[b][31:16];
        aex = ax + wa;
        aey = ay + ha;
        bex = bx + wb;
        bey = by + hb;
        if (aex < bx || ax >= bex)
            return 1'b0;
        if (aey < by || ay > bey)
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic predict_emission(input t_req w);
        logic [IDX_W-1:0] i;
        logic [15:0]      sz;
        int               count;
        t_result          r;
        i = w.sprite_index;
        r = '0;
        case (w.req_type)
            REQ_SET_POS: begin
                if (int'(i) < SPRITE_COUNT)
                    sprite_pos[i] = {w.pos_y, w.pos_x};
            end
            REQ_SET_TYPE: begin
                if (int'(i) < SPRITE_COUNT)
                    sprite_attr[i][3:0] = w.sprite_type;
            end
            REQ_SET_VIS: begin
                if (int'(i) < SPRITE_COUNT)
                    sprite_attr[i][4] = w.visible_flag;
            end
            REQ_SET_TILES: begin
                if (int'(i) < SPRITE_COUNT)
                    sprite_tiles[i] = {w.tile_3, w.tile_2, w.tile_1, w.tile_0};
            end
            REQ_DRAW: begin
                sz = {10'd0, pixels_per_tile(sprite_attr[i][3:0])};
                if (int'(i) < SPRITE_COUNT && sprite_attr[i][4] && sz != 16'd0) begin
                    case (sprite_attr[i][1:0])
                        SHAPE_1X1: count = 1;
                        SHAPE_2X2: count = 4;
                        default:   count = 2;
                    endcase
                    for (int k = 0; k < count; k++) begin
                        r.result_kind = RESULT_TILE;
                        r.tile_x = sprite_pos[i][15:0] + ((k == 1 || k == 3) ? sz : 16'd0);
                        r.tile_y = sprite_pos[i][31:16] + ((k == 2 || k == 3) ? sz : 16'd0);
                        r.tile_number = sprite_tiles[i][8*k +: 8];
                        r.collided = 1'b0;
                        r.last = (k == count - 1);
                        due_words.push_back(r);
                    end
                end
            end
            REQ_COLLIDE: begin
                r.result_kind = RESULT_COLLIDE;
                r.collided = boxes_meet(w.sprite_index, w.other_index);
                r.last = 1'b1;
                due_words.push_back(r);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (due_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: kind %0d x %h y %h tile %h hit %0d last %0d",
                             o_result.result_kind, o_result.tile_x, o_result.tile_y,
                             o_result.tile_number, o_result.collided, o_result.last);
            end else begin
                head_word = due_words.pop_front();
                if (o_result.result_kind !== head_word.result_kind
                        || o_result.tile_x !== head_word.tile_x
                        || o_result.tile_y !== head_word.tile_y
                        || o_result.tile_number !== head_word.tile_number
                        || o_result.collided !== head_word.collided
                        || o_result.last !== head_word.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected kind %0d x %h y %h tile %h hit %0d last %0d",
                                 head_word.result_kind, head_word.tile_x, head_word.tile_y,
                                 head_word.tile_number, head_word.collided, head_word.last);
                        $display("          got      kind %0d x %h y %h tile %h hit %0d last %0d",
                                 o_result.result_kind, o_result.tile_x, o_result.tile_y,
                                 o_result.tile_number, o_result.collided, o_result.last);
                    end
                end
            end
        end
    end

    function automatic t_req scrambled_word(input logic [2:0] code);
        t_req w;
        w.req_type = code;
        w.sprite_index = IDX_W'($urandom_range(63, 0));
        w.other_index = IDX_W'($urandom_range(63, 0));
        w.pos_x = 16'($urandom);
        w.pos_y = 16'($urandom);
        w.sprite_type = 4'($urandom);
        w.visible_flag = 1'($urandom);
        w.tile_0 = 8'($urandom);
        w.tile_1 = 8'($urandom);
        w.tile_2 = 8'($urandom);
        w.tile_3 = 8'($urandom);
        return w;
    endfunction

    task automatic send_word(input t_req w);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= w;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predict_emission(w);
    endtask

    task automatic send_cmd(input logic [2:0] code, input int idx, input int other,
                            input int x, input int y, input int stype, input int vis,
                            input logic [31:0] tiles);
        t_req w;
        w = scrambled_word(code);
        if (idx >= 0) w.sprite_index = IDX_W'(idx);
        if (other >= 0) w.other_index = IDX_W'(other);
        if (x >= 0) w.pos_x = 16'(x);
        if (y >= 0) w.pos_y = 16'(y);
        if (stype >= 0) w.sprite_type = 4'(stype);
        if (vis >= 0) w.visible_flag = 1'(vis);
        {w.tile_3, w.tile_2, w.tile_1, w.tile_0} = tiles;
        send_word(w);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_cleared_table();
        send_cmd(REQ_DRAW, 0, -1, -1, -1, -1, -1, 32'($urandom));
        send_cmd(REQ_COLLIDE, 0, 63, -1, -1, -1, -1, 32'($urandom));
    endtask

    task automatic test_draw_shapes();
        send_cmd(REQ_SET_POS, 1, -1, 16'hFFF8, 16'hFFF0, -1, -1, 32'($urandom));
        send_cmd(REQ_SET_TILES, 1, -1, -1, -1, -1, -1, 32'h5AA5FF00);
        send_cmd(REQ_SET_VIS, 1, -1, -1, -1, -1, 1, 32'($urandom));
        send_cmd(REQ_SET_TYPE, 1, -1, -1, -1, {GROUP_32, SHAPE_2X2}, -1, 32'($urandom));
        send_cmd(REQ_DRAW, 1, -1, -1, -1, -1, -1, 32'($urandom));
        send_cmd(REQ_SET_TYPE, 1, -1, -1, -1, {GROUP_8, SHAPE_1X2}, -1, 32'($urandom));
        send_cmd(REQ_DRAW, 1, -1, -1, -1, -1, -1, 32'($urandom));
        send_cmd(REQ_SET_TYPE, 1, -1, -1, -1, {GROUP_16, SHAPE_2X1}, -1, 32'($urandom));
        send_cmd(REQ_DRAW, 1, -1, -1, -1, -1, -1, 32'($urandom));
        send_cmd(REQ_SET_TYPE, 1, -1, -1, -1, {GROUP_8, SHAPE_1X1}, -1, 32'($urandom));
        send_cmd(REQ_DRAW, 1, -1, -1, -1, -1, -1, 32'($urandom));
        send_cmd(REQ_SET_TYPE, 1, -1, -1, -1, {GROUP_NONE, SHAPE_2X2}, -1, 32'($urandom));
        send_cmd(REQ_DRAW, 1, -1, -1, -1, -1, -1, 32'($urandom));
        send_cmd(REQ_SET_VIS, 1, -1, -1, -1, -1, 0, 32'($urandom));
        send_cmd(REQ_DRAW, 1, -1, -1, -1, -1, -1, 32'($urandom));
    endtask

    // Sprite 2 ends exactly where sprite 3 begins, so the test only hits one way round.
    task automatic test_collision_edges();
        send_cmd(REQ_SET_POS, 2, -1, 0, 0, -1, -1, 32'($urandom));
        send_cmd(REQ_SET_TYPE, 2, -1, -1, -1, {GROUP_8, SHAPE_1X1}, -1, 32'($urandom));
        send_cmd(REQ_SET_VIS, 2, -1, -1, -1, -1, 1, 32'($urandom));
        send_cmd(REQ_SET_POS, 3, -1, 7, 7, -1, -1, 32'($urandom));
        send_cmd(REQ_SET_TYPE, 3, -1, -1, -1, {GROUP_8, SHAPE_1X1}, -1, 32'($urandom));
        send_cmd(REQ_SET_VIS, 3, -1, -1, -1, -1, 1, 32'($urandom));
        send_cmd(REQ_COLLIDE, 2, 3, -1, -1, -1, -1, 32'($urandom));
        send_cmd(REQ_COLLIDE, 3, 2, -1, -1, -1, -1, 32'($urandom));
    endtask

    task automatic test_spare_command();
        send_cmd(REQ_SPARE_7, -1, -1, -1, -1, -1, -1, 32'($urandom));
    endtask

    function automatic int pick_sprite();
        return ($urandom_range(9, 0) < 8) ? $urandom_range(7, 0) : $urandom_range(63, 0);
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4, 5: return $urandom_range(96, 0);
            6, 7:             return 16'hFFC0 + $urandom_range(63, 0);
            8:                return $urandom_range(1, 0) ? 16'hFFFF : 0;
            default:          return $urandom_range(65535, 0);
        endcase
    endfunction

    task automatic test_random_traffic(input int words, input int idle_pct);
        int sent;
        int pick;
        sent = 0;
        sender_idle_pct = idle_pct;
        while (sent < words) begin
            pick = $urandom_range(99, 0);
            sent++;
            if (pick < 16)
                send_cmd(REQ_SET_POS, pick_sprite(), -1, pick_coord(), pick_coord(), -1, -1,
                         32'($urandom));
            else if (pick < 28)
                send_cmd(REQ_SET_TYPE, pick_sprite(), -1, -1, -1,
                         ($urandom_range(9, 0) < 8) ? $urandom_range(11, 0)
                                                    : $urandom_range(15, 12),
                         -1, 32'($urandom));
            else if (pick < 40)
                send_cmd(REQ_SET_VIS, pick_sprite(), -1, -1, -1, -1,
                         ($urandom_range(9, 0) < 8) ? 1 : 0, 32'($urandom));
            else if (pick < 50)
                send_cmd(REQ_SET_TILES, pick_sprite(), -1, -1, -1, -1, -1, 32'($urandom));
            else if (pick < 75)
                send_cmd(REQ_DRAW, pick_sprite(), -1, -1, -1, -1, -1, 32'($urandom));
            else if (pick < 95)
                send_cmd(REQ_COLLIDE, pick_sprite(), pick_sprite(), -1, -1, -1, -1,
                         32'($urandom));
            else begin
                sent--;
                send_cmd($urandom_range(1, 0) ? REQ_SPARE_6 : REQ_SPARE_7, -1, -1, -1, -1,
                         -1, -1, 32'($urandom));
            end
        end
    endtask

    initial begin
        for (int s = 0; s < SPRITE_COUNT; s++) begin
            sprite_pos[s] = '0;
            sprite_attr[s] = '0;
            sprite_tiles[s] = '0;
        end
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 10;
        test_cleared_table();
        test_draw_shapes();
        test_collision_edges();
        test_spare_command();
        drain_results();
        test_random_traffic(RANDOM_WORDS / 3, 10);
        drain_results();
        test_random_traffic(RANDOM_WORDS / 3, 80);
        drain_results();
        test_random_traffic(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3), 0);
        drain_results();
        if (mismatch_count == 0 && due_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
